// ----- hdl/kfts_pkg.sv -----
// kfts_pkg: shared types, register-file addresses and the micro-op program
// for the three-state kalman filter; no dependencies
`default_nettype none

package kfts_pkg;

   localparam int MEM_DEPTH = 18;
   localparam int UC_LEN    = 36;

   typedef logic [4:0] addr_type;
   typedef logic [5:0] pc_type;

   // register-file map: state, covariance (row major), gains, scratch
   localparam addr_type A_X0 = 5'd0;
   localparam addr_type A_X1 = 5'd1;
   localparam addr_type A_X2 = 5'd2;
   localparam addr_type A_P0 = 5'd3;
   localparam addr_type A_P1 = 5'd4;
   localparam addr_type A_P2 = 5'd5;
   localparam addr_type A_P3 = 5'd6;
   localparam addr_type A_P4 = 5'd7;
   localparam addr_type A_P5 = 5'd8;
   localparam addr_type A_P6 = 5'd9;
   localparam addr_type A_P7 = 5'd10;
   localparam addr_type A_P8 = 5'd11;
   localparam addr_type A_K0 = 5'd12;
   localparam addr_type A_K1 = 5'd13;
   localparam addr_type A_K2 = 5'd14;
   localparam addr_type A_E  = 5'd15;
   localparam addr_type A_S  = 5'd16;
   localparam addr_type A_Z  = 5'd17;

   typedef enum logic [1:0] {
      CSR_TIME_STEP  = 2'd0,
      CSR_MEAS_NOISE = 2'd1,
      CSR_PROC_NOISE = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      K_MUL_ADD = 3'd0,   // wd = c + a * b
      K_MUL_SUB = 3'd1,   // wd = c - a * b
      K_ADD_Q   = 3'd2,   // wd = a + q
      K_ADD_R   = 3'd3,   // wd = a + r
      K_SUB     = 3'd4,   // wd = a - b
      K_GAIN    = 3'd5,   // wd = a / b, zero when b is zero
      K_REL     = 3'd6    // relative error |a| / |b|
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     use_dt;
      addr_type ra;
      addr_type rb;
      addr_type rc;
      addr_type wd;
   } uop_type;

   function automatic uop_type mk(kind_type k, logic dt, addr_type ra, addr_type rb,
                                  addr_type rc, addr_type wd);
      uop_type u;
      u.kind   = k;
      u.use_dt = dt;
      u.ra     = ra;
      u.rb     = rb;
      u.rc     = rc;
      u.wd     = wd;
      return u;
   endfunction

   // one filter cycle: predict, add noise, gain, correct, relative error
   function automatic uop_type ucode(pc_type pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(K_MUL_ADD, 1'b1, A_X1, A_X0, A_X0, A_X0);
         6'd1:  u = mk(K_MUL_ADD, 1'b1, A_X2, A_X0, A_X1, A_X1);
         6'd2:  u = mk(K_MUL_ADD, 1'b1, A_P3, A_P0, A_P0, A_P0);
         6'd3:  u = mk(K_MUL_ADD, 1'b1, A_P4, A_P0, A_P1, A_P1);
         6'd4:  u = mk(K_MUL_ADD, 1'b1, A_P5, A_P0, A_P2, A_P2);
         6'd5:  u = mk(K_MUL_ADD, 1'b1, A_P6, A_P0, A_P3, A_P3);
         6'd6:  u = mk(K_MUL_ADD, 1'b1, A_P7, A_P0, A_P4, A_P4);
         6'd7:  u = mk(K_MUL_ADD, 1'b1, A_P8, A_P0, A_P5, A_P5);
         6'd8:  u = mk(K_MUL_ADD, 1'b1, A_P1, A_P0, A_P0, A_P0);
         6'd9:  u = mk(K_MUL_ADD, 1'b1, A_P2, A_P0, A_P1, A_P1);
         6'd10: u = mk(K_MUL_ADD, 1'b1, A_P4, A_P0, A_P3, A_P3);
         6'd11: u = mk(K_MUL_ADD, 1'b1, A_P5, A_P0, A_P4, A_P4);
         6'd12: u = mk(K_MUL_ADD, 1'b1, A_P7, A_P0, A_P6, A_P6);
         6'd13: u = mk(K_MUL_ADD, 1'b1, A_P8, A_P0, A_P7, A_P7);
         6'd14: u = mk(K_ADD_Q,   1'b0, A_P0, A_P0, A_P0, A_P0);
         6'd15: u = mk(K_ADD_Q,   1'b0, A_P1, A_P0, A_P0, A_P1);
         6'd16: u = mk(K_ADD_Q,   1'b0, A_P3, A_P0, A_P0, A_P3);
         6'd17: u = mk(K_ADD_Q,   1'b0, A_P4, A_P0, A_P0, A_P4);
         6'd18: u = mk(K_SUB,     1'b0, A_Z,  A_X0, A_X0, A_E);
         6'd19: u = mk(K_ADD_R,   1'b0, A_P0, A_P0, A_P0, A_S);
         6'd20: u = mk(K_GAIN,    1'b0, A_P0, A_S,  A_P0, A_K0);
         6'd21: u = mk(K_GAIN,    1'b0, A_P3, A_S,  A_P0, A_K1);
         6'd22: u = mk(K_GAIN,    1'b0, A_P6, A_S,  A_P0, A_K2);
         6'd23: u = mk(K_MUL_ADD, 1'b0, A_K0, A_E,  A_X0, A_X0);
         6'd24: u = mk(K_MUL_ADD, 1'b0, A_K1, A_E,  A_X1, A_X1);
         6'd25: u = mk(K_MUL_ADD, 1'b0, A_K2, A_E,  A_X2, A_X2);
         6'd26: u = mk(K_MUL_SUB, 1'b0, A_K2, A_P0, A_P6, A_P6);
         6'd27: u = mk(K_MUL_SUB, 1'b0, A_K2, A_P1, A_P7, A_P7);
         6'd28: u = mk(K_MUL_SUB, 1'b0, A_K2, A_P2, A_P8, A_P8);
         6'd29: u = mk(K_MUL_SUB, 1'b0, A_K1, A_P0, A_P3, A_P3);
         6'd30: u = mk(K_MUL_SUB, 1'b0, A_K1, A_P1, A_P4, A_P4);
         6'd31: u = mk(K_MUL_SUB, 1'b0, A_K1, A_P2, A_P5, A_P5);
         6'd32: u = mk(K_MUL_SUB, 1'b0, A_K0, A_P0, A_P0, A_P0);
         6'd33: u = mk(K_MUL_SUB, 1'b0, A_K0, A_P1, A_P1, A_P1);
         6'd34: u = mk(K_MUL_SUB, 1'b0, A_K0, A_P2, A_P2, A_P2);
         default: u = mk(K_REL,   1'b0, A_E,  A_Z,  A_E,  A_E);
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/kfts_mul.sv -----
// kfts_mul: multi-cycle fixed-point multiplier, 16-bit slices of b per cycle,
// round to nearest and saturate; no dependencies
`default_nettype none

module kfts_mul #(
   parameter int DW = 48,
   parameter int FW = 24,
   parameter int MW = 48
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          neg,
   input  wire logic [MW-1:0] a_mag,
   input  wire logic [MW-1:0] b_mag,
   output logic               done,
   output logic [DW-1:0]      result
);
   localparam int SW  = 16;
   localparam int NCH = (MW + SW - 1) / SW;
   localparam int BW  = NCH * SW;
   localparam int PW  = MW + BW;
   localparam int CW  = $clog2(NCH + 1);
   localparam logic [PW-1:0] HALF = PW'(1) << (FW - 1);
   localparam logic [PW-1:0] UMAX = (PW'(1) << (DW - 1)) - PW'(1);
   localparam logic [DW-1:0] MINMAG = DW'(1) << (DW - 1);

   logic [MW-1:0]    amag_ff;
   logic [BW-1:0]    bsh_ff;
   logic [PW-1:0]    acc_ff, acc_in;
   logic [CW-1:0]    cnt_ff;
   logic             neg_ff, rnd_ff, pk_ff, done_ff;
   logic [DW-1:0]    mag_ff, mag_in, res_ff;
   logic [MW+SW-1:0] part;
   logic [PW-1:0]    rnd_sum, rnd_m;

   always_comb begin
      part    = amag_ff * bsh_ff[BW-1 -: SW];
      acc_in  = (acc_ff << SW) + PW'(part);
      rnd_sum = acc_ff + HALF;
      rnd_m   = rnd_sum >> FW;
      if (rnd_m > UMAX) begin
         mag_in = neg_ff ? MINMAG : UMAX[DW-1:0];
      end else begin
         mag_in = rnd_m[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rnd_ff  <= 1'b0;
         pk_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            amag_ff <= a_mag;
            bsh_ff  <= BW'(b_mag);
            acc_ff  <= '0;
            neg_ff  <= neg;
            cnt_ff  <= CW'(NCH);
         end else if (cnt_ff != '0) begin
            acc_ff <= acc_in;
            bsh_ff <= bsh_ff << SW;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               rnd_ff <= 1'b1;
            end
         end else if (rnd_ff) begin
            mag_ff <= mag_in;
            rnd_ff <= 1'b0;
            pk_ff  <= 1'b1;
         end else if (pk_ff) begin
            res_ff  <= neg_ff ? DW'(-mag_ff) : mag_ff;
            pk_ff   <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// ----- hdl/kfts_div.sv -----
// kfts_div: restoring divider, (num << FW) / den one quotient bit a cycle,
// round to nearest and clamp; no dependencies
`default_nettype none

module kfts_div #(
   parameter int DW = 48,
   parameter int FW = 24
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [DW-2:0]      quot,
   output logic               ovf
);
   localparam int NB = DW + FW;
   localparam int CW = $clog2(NB + 1);
   localparam logic [NB:0] UMAX = ((NB + 1)'(1) << (DW - 1)) - (NB + 1)'(1);

   logic [NB-1:0] nsh_ff, q_ff, q_in;
   logic [DW-1:0] den_ff, rem_ff, rem_in;
   logic [DW:0]   trial, trial_sub;
   logic          ge, up, sat;
   logic [NB:0]   qr;
   logic [CW-1:0] cnt_ff;
   logic          rnd_ff, done_ff, ovf_ff;
   logic [DW-2:0] quot_ff;

   always_comb begin
      trial     = {rem_ff, nsh_ff[NB-1]};
      trial_sub = trial - {1'b0, den_ff};
      ge        = trial >= {1'b0, den_ff};
      rem_in    = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      q_in      = {q_ff[NB-2:0], ge};
      up        = rem_ff >= (den_ff - rem_ff);
      qr        = {1'b0, q_ff} + (NB + 1)'(up);
      sat       = qr > UMAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            nsh_ff <= {num, FW'(0)};
            den_ff <= den;
            rem_ff <= '0;
            q_ff   <= '0;
            cnt_ff <= CW'(NB);
         end else if (cnt_ff != '0) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            nsh_ff <= nsh_ff << 1;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               rnd_ff <= 1'b1;
            end
         end else if (rnd_ff) begin
            quot_ff <= sat ? UMAX[DW-2:0] : qr[DW-2:0];
            ovf_ff  <= sat;
            rnd_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign ovf  = ovf_ff;

endmodule

`default_nettype wire

// ----- hdl/kalman_filter_three_state.sv -----
// a measurement item runs the micro-op program and gives rsp_tvalid from the output step;
//   the four divides use the restoring divider and the 26 multiplies go through the
//   16-bit-slice multiplier
// a zero divisor skips its divide (a zero measurement skips the relative-error divide)
// an initialize item loads state and covariance presets, then gives rsp_tvalid from the output step
// throughput: one item at a time, req_tready is high only while the sequencer is idle
// reset: synchronous; after reset a load fills state and covariance presets
`default_nettype none

// kalman_filter_three_state: top level, micro-op sequencer with register file,
// shared multiplier and divider; uses kfts_pkg, kfts_mul, kfts_div
module kalman_filter_three_state #(
   parameter int FRAC_BITS  = 24,
   parameter int DATA_WIDTH = 48
) (
   input  wire logic clock,
   input  wire logic reset,
   // input channel
   input  wire logic req_tvalid,
   output logic      req_tready,
   // measurement, init_position, init_velocity, init_acceleration, init_time
   input  wire logic [((4*DATA_WIDTH+63+7)/8)*8-1:0] req_tdata,
   // mode
   input  wire logic [0:0] req_tuser,
   // result channel
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // est_position, est_velocity, est_acceleration, relative_error, time_now
   output logic [((4*DATA_WIDTH-1+63+7)/8)*8-1:0] rsp_tdata,
   // error_invalid
   output logic [0:0] rsp_tuser,
   // configuration writes
   input  wire logic csr_we,
   input  wire kfts_pkg::csr_type csr_addr,
   input  wire logic [((FRAC_BITS+1) > (DATA_WIDTH-1) ? (FRAC_BITS+1) : (DATA_WIDTH-1))-1:0]
                     csr_wdata
);
   import kfts_pkg::*;

   localparam int DW   = DATA_WIDTH;
   localparam int FW   = FRAC_BITS;
   localparam int TSW  = FW + 1;
   localparam int NW   = DW - 1;
   localparam int MW   = DW > TSW ? DW : TSW;
   localparam int TW   = 63;
   localparam int RSPW = ((3*DW + NW + TW + 7) / 8) * 8;

   localparam logic [127:0] ONE    = 128'd1 << FW;
   localparam logic [127:0] UMAX_W = (128'd1 << (DW - 1)) - 128'd1;

   localparam logic [DW-1:0] VMAX  = UMAX_W[DW-1:0];
   localparam logic [DW-1:0] VMIN  = ~UMAX_W[DW-1:0];
   localparam logic [NW-1:0] UMAXN = UMAX_W[NW-1:0];
   localparam logic [TW-1:0] TMAX  = '1;

   function automatic logic [DW-1:0] clampc(logic [127:0] v);
      return (v > UMAX_W) ? UMAX_W[DW-1:0] : v[DW-1:0];
   endfunction

   // covariance presets and register reset values, rounded and clamped
   localparam logic [DW-1:0] P_TENTH = clampc((ONE + 128'd5) / 128'd10);
   localparam logic [DW-1:0] P_BIG   = clampc(ONE * 128'd10000);
   localparam logic [DW-1:0] P_TEN   = clampc(ONE * 128'd10);
   localparam logic [DW-1:0] P_HUND  = clampc(ONE * 128'd100);
   localparam logic [127:0]  DT_W    = (ONE + 128'd15) / 128'd30;
   localparam logic [DW-1:0] R_RST   = clampc(ONE * 128'd5);
   localparam logic [DW-1:0] Q_RST   = clampc((ONE + 128'd10) / 128'd20);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_LOAD = 8'b0000_0010,
      ST_RD1  = 8'b0000_0100,
      ST_RD2  = 8'b0000_1000,
      ST_RUN  = 8'b0001_0000,
      ST_WB   = 8'b0010_0000,
      ST_FIN  = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   // saturating two's complement helpers
   function automatic logic [DW-1:0] sat_add(logic [DW-1:0] a, logic [DW-1:0] b);
      logic [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) begin
         return s[DW] ? VMIN : VMAX;
      end
      return s[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] sat_sub(logic [DW-1:0] a, logic [DW-1:0] b);
      logic [DW:0] s;
      s = {a[DW-1], a} - {b[DW-1], b};
      if (s[DW] != s[DW-1]) begin
         return s[DW] ? VMIN : VMAX;
      end
      return s[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] mag(logic [DW-1:0] a);
      return a[DW-1] ? DW'(-a) : a;
   endfunction

   function automatic logic [DW-1:0] preset(addr_type a);
      logic [DW-1:0] v;
      case (a) inside
         A_P4:       v = P_BIG;
         A_P5, A_P7: v = P_TEN;
         A_P8:       v = P_HUND;
         default:    v = P_TENTH;
      endcase
      return v;
   endfunction

   // control state
   state_type state_ff, state_in;
   pc_type    pc_ff, pc_in;
   addr_type  ld_cnt_ff, ld_cnt_in;
   logic      item_ff, item_in;
   logic      skip_ff, skip_in;
   logic      gsign_ff, gsign_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // configuration and time
   logic [TSW-1:0] dt_ff;
   logic [NW-1:0]  rn_ff, qn_ff;
   logic [TW-1:0]  time_ff, time_in;
   logic [TW:0]    time_sum;

   // payload
   logic [DW-1:0]   init_x_ff [3];
   logic [DW-1:0]   est_ff [3];
   logic [NW-1:0]   rel_ff, rel_in;
   logic            inval_ff, inval_in;
   logic [RSPW-1:0] rsp_data_ff, rsp_data_in;
   logic            rsp_user_ff, rsp_user_in;

   // register file
   logic [DW-1:0] rf_mem [MEM_DEPTH];
   logic [DW-1:0] rd0_ff, rd1_ff;
   addr_type      rd0_addr, rd1_addr, wr_addr;
   logic          rd0_en, rd1_en, wr_en;
   logic [DW-1:0] wr_data;

   // shared units
   logic          mul_start, mul_neg, mul_done;
   logic [MW-1:0] mul_a, mul_b;
   logic [DW-1:0] mul_res;
   logic          div_start, div_done, div_ovf;
   logic [DW-1:0] div_num, div_den;
   logic [NW-1:0] div_q;

   uop_type       uop;
   logic          req_xfer, rsp_xfer, mode;
   logic [DW-1:0] gain_val;

   assign uop      = ucode(pc_ff);
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_valid_ff && rsp_tready;
   assign mode     = req_tuser[0];
   assign time_sum = {1'b0, time_ff} + (TW + 1)'(dt_ff);

   // operand routing into the shared units
   always_comb begin
      mul_a   = MW'(mag(rd0_ff));
      mul_b   = uop.use_dt ? MW'(dt_ff) : MW'(mag(rd1_ff));
      mul_neg = uop.use_dt ? rd0_ff[DW-1] : (rd0_ff[DW-1] ^ rd1_ff[DW-1]);
      div_num = mag(rd0_ff);
      div_den = mag(rd1_ff);
      if (skip_ff) begin
         gain_val = '0;
      end else if (gsign_ff) begin
         gain_val = div_ovf ? VMIN : DW'(-{1'b0, div_q});
      end else begin
         gain_val = {1'b0, div_q};
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      ld_cnt_in    = ld_cnt_ff;
      item_in      = item_ff;
      skip_in      = skip_ff;
      gsign_in     = gsign_ff;
      time_in      = time_ff;
      rel_in       = rel_ff;
      inval_in     = inval_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rd0_addr     = uop.ra;
      rd1_addr     = uop.rb;
      rd0_en       = 1'b0;
      rd1_en       = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = uop.wd;
      wr_data      = '0;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               if (mode) begin
                  time_in   = req_tdata[4*DW +: TW];
                  rel_in    = '0;
                  inval_in  = 1'b0;
                  item_in   = 1'b1;
                  ld_cnt_in = A_X0;
                  state_in  = ST_LOAD;
               end else begin
                  // measurement goes straight into the register file
                  wr_en    = 1'b1;
                  wr_addr  = A_Z;
                  wr_data  = req_tdata[DW-1:0];
                  pc_in    = '0;
                  state_in = ST_RD1;
               end
            end
         end
         ST_LOAD: begin
            // state from the item (zero after reset), covariance from presets
            wr_en   = 1'b1;
            wr_addr = ld_cnt_ff;
            wr_data = (ld_cnt_ff < A_P0) ? init_x_ff[ld_cnt_ff[1:0]] : preset(ld_cnt_ff);
            ld_cnt_in = ld_cnt_ff + addr_type'(1);
            if (ld_cnt_ff == A_P8) begin
               state_in = item_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_RD1: begin
            rd0_en   = 1'b1;
            rd1_en   = 1'b1;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            skip_in  = (rd1_ff == '0);
            gsign_in = rd0_ff[DW-1] ^ rd1_ff[DW-1];
            case (uop.kind) inside
               K_MUL_ADD, K_MUL_SUB: begin
                  mul_start = 1'b1;
                  rd0_addr  = uop.rc;
                  rd0_en    = 1'b1;
                  state_in  = ST_RUN;
               end
               K_GAIN, K_REL: begin
                  if (rd1_ff == '0) begin
                     state_in = ST_WB;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_RUN;
                  end
               end
               default: begin
                  state_in = ST_WB;
               end
            endcase
         end
         ST_RUN: begin
            if ((uop.kind == K_MUL_ADD || uop.kind == K_MUL_SUB) ? mul_done : div_done) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            wr_en = 1'b1;
            case (uop.kind)
               K_MUL_ADD: wr_data = sat_add(rd0_ff, mul_res);
               K_MUL_SUB: wr_data = sat_sub(rd0_ff, mul_res);
               K_ADD_Q:   wr_data = sat_add(rd0_ff, {1'b0, qn_ff});
               K_ADD_R:   wr_data = sat_add(rd0_ff, {1'b0, rn_ff});
               K_SUB:     wr_data = sat_sub(rd0_ff, rd1_ff);
               K_GAIN:    wr_data = gain_val;
               default: begin
                  // relative error: saturated when the measurement was zero
                  wr_en    = 1'b0;
                  rel_in   = skip_ff ? UMAXN : div_q;
                  inval_in = skip_ff;
               end
            endcase
            if (pc_ff == pc_type'(UC_LEN - 1)) begin
               state_in = ST_FIN;
            end else begin
               pc_in    = pc_ff + pc_type'(1);
               state_in = ST_RD1;
            end
         end
         ST_FIN: begin
            time_in  = time_sum[TW] ? TMAX : time_sum[TW-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = RSPW'({time_ff, rel_ff, est_ff[2], est_ff[1], est_ff[0]});
               rsp_user_in  = inval_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register file, registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem[wr_addr] <= wr_data;
      end
      if (rd0_en) begin
         rd0_ff <= rf_mem[rd0_addr];
      end
      if (rd1_en) begin
         rd1_ff <= rf_mem[rd1_addr];
      end
   end

   // copy of the state estimate for the result
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (wr_en && wr_addr == addr_type'(i)) begin
            est_ff[i] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pc_ff        <= '0;
         ld_cnt_ff    <= A_X0;
         item_ff      <= 1'b0;
         skip_ff      <= 1'b0;
         gsign_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
         rel_ff       <= '0;
         inval_ff     <= 1'b0;
         dt_ff        <= DT_W[TSW-1:0];
         rn_ff        <= R_RST[NW-1:0];
         qn_ff        <= Q_RST[NW-1:0];
         for (int i = 0; i < 3; i++) begin
            init_x_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         ld_cnt_ff    <= ld_cnt_in;
         item_ff      <= item_in;
         skip_ff      <= skip_in;
         gsign_ff     <= gsign_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
         rel_ff       <= rel_in;
         inval_ff     <= inval_in;
         if (req_xfer && mode) begin
            for (int i = 0; i < 3; i++) begin
               init_x_ff[i] <= req_tdata[(i+1)*DW +: DW];
            end
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_TIME_STEP:  dt_ff <= csr_wdata[TSW-1:0];
               CSR_MEAS_NOISE: rn_ff <= csr_wdata[NW-1:0];
               CSR_PROC_NOISE: qn_ff <= csr_wdata[NW-1:0];
               default: ;
            endcase
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   kfts_mul #(
      .DW (DW),
      .FW (FW),
      .MW (MW)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .neg    (mul_neg),
      .a_mag  (mul_a),
      .b_mag  (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   kfts_div #(
      .DW (DW),
      .FW (FW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q),
      .ovf   (div_ovf)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // the two shared units never finish together
   assert property (@(posedge clock) disable iff (reset) !(mul_done && div_done))
      else $error("multiplier and divider done together");

   // program counter stays inside the micro-op program
   assert property (@(posedge clock) disable iff (reset) pc_ff < pc_type'(UC_LEN))
      else $error("program counter out of range");

   // a new result only comes out of the output step
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |-> state_ff == ST_OUT)
      else $error("result raised outside output step");

   // a measurement transfer starts the program at its first read
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !mode) |=> (state_ff == ST_RD1 && pc_ff == '0))
      else $error("measurement transfer did not start the program");
`endif

endmodule

`default_nettype wire

// ----- verif/kalman_filter_three_state_checker.sv -----
// kalman_filter_three_state_checker: watches the request, response and csr ports,
// predicts each filter result in fixed point and compares it; uses kfts_pkg
`timescale 1ns / 100ps

module kalman_filter_three_state_checker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire logic          req_tready,
   input  wire logic [255:0]  req_tdata,
   input  wire logic [0:0]    req_tuser,
   input  wire logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic [255:0]  rsp_tdata,
   input  wire logic [0:0]    rsp_tuser,
   input  wire logic          csr_we,
   input  wire kfts_pkg::csr_type csr_addr,
   input  wire logic [46:0]   csr_wdata,
   output int                 mismatch_count,
   output int                 results_pending
);
   import kfts_pkg::*;

   localparam longint VMAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint VMIN = -VMAX - 1;
   localparam logic [62:0] TMAX = '1;

   typedef struct {
      logic [47:0] pos, vel, acc;
      logic [46:0] rel;
      logic        inval;
      logic [62:0] tm;
   } estimate_type;

   estimate_type estimates_due[$];
   longint      xs[3];
   longint      pc[9];
   logic [62:0] clock_now;
   logic [24:0] dt_reg;
   logic [46:0] r_reg, q_reg;

   function automatic logic [127:0] mag(longint a);
      return (a < 0) ? 128'(-a) : 128'(a);
   endfunction

   function automatic longint pack(logic neg, logic [127:0] m);
      if (m > 128'(VMAX)) return neg ? VMIN : VMAX;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      return (s > VMAX) ? VMAX : (s < VMIN) ? VMIN : s;
   endfunction

   function automatic longint ssub(longint a, longint b);
      longint s;
      s = a - b;
      return (s > VMAX) ? VMAX : (s < VMIN) ? VMIN : s;
   endfunction

   function automatic longint fmul(longint a, longint b);
      logic [127:0] p;
      p = (mag(a) * mag(b) + (128'd1 << 23)) >> 24;
      return pack((a < 0) != (b < 0), p);
   endfunction

   // rounded (n << 24) / d, ties away from zero
   function automatic logic [127:0] udiv(logic [127:0] n, logic [127:0] d);
      logic [127:0] q, r;
      q = (n << 24) / d;
      r = (n << 24) % d;
      if (2 * r >= d) q = q + 1;
      return q;
   endfunction

   function automatic longint sx48(logic [47:0] v);
      return longint'($signed(v));
   endfunction

   task automatic load_preset();
      longint tenth;
      tenth = 1677722;
      pc[0] = tenth; pc[1] = tenth; pc[2] = tenth;
      pc[3] = tenth; pc[4] = 10000 * 64'sd16777216; pc[5] = 10 * 64'sd16777216;
      pc[6] = tenth; pc[7] = 10 * 64'sd16777216; pc[8] = 100 * 64'sd16777216;
   endtask

   task automatic filter_step(logic mode, logic [255:0] d);
      longint xp[3], a[3][3], pp[3][3], k[3], z, e, s, dt;
      logic [127:0] m;
      estimate_type est;
      est.rel = '0;
      est.inval = 1'b0;
      if (mode) begin
         xs[0] = sx48(d[95:48]);
         xs[1] = sx48(d[143:96]);
         xs[2] = sx48(d[191:144]);
         load_preset();
         clock_now = d[254:192];
      end else begin
         dt = longint'(dt_reg);
         xp[0] = sadd(xs[0], fmul(dt, xs[1]));
         xp[1] = sadd(xs[1], fmul(dt, xs[2]));
         xp[2] = xs[2];
         for (int j = 0; j < 3; j++) begin
            a[0][j] = sadd(pc[j], fmul(dt, pc[3+j]));
            a[1][j] = sadd(pc[3+j], fmul(dt, pc[6+j]));
            a[2][j] = pc[6+j];
         end
         for (int i = 0; i < 3; i++) begin
            pp[i][0] = sadd(a[i][0], fmul(dt, a[i][1]));
            pp[i][1] = sadd(a[i][1], fmul(dt, a[i][2]));
            pp[i][2] = a[i][2];
         end
         // process noise only on the position/velocity block
         pp[0][0] = sadd(pp[0][0], longint'(q_reg));
         pp[0][1] = sadd(pp[0][1], longint'(q_reg));
         pp[1][0] = sadd(pp[1][0], longint'(q_reg));
         pp[1][1] = sadd(pp[1][1], longint'(q_reg));
         z = sx48(d[47:0]);
         e = ssub(z, xp[0]);
         s = sadd(pp[0][0], longint'(r_reg));
         // zero innovation variance gives zero gain
         for (int i = 0; i < 3; i++)
            k[i] = (s == 0) ? 0 : pack((pp[i][0] < 0) != (s < 0), udiv(mag(pp[i][0]), mag(s)));
         for (int i = 0; i < 3; i++) begin
            xs[i] = sadd(xp[i], fmul(k[i], e));
            for (int j = 0; j < 3; j++) pc[i*3+j] = ssub(pp[i][j], fmul(k[i], pp[0][j]));
         end
         if (z == 0) begin
            est.rel = '1;
            est.inval = 1'b1;
         end else begin
            m = udiv(mag(e), mag(z));
            est.rel = (m > 128'(VMAX)) ? 47'(VMAX) : m[46:0];
         end
         clock_now = (TMAX - clock_now < 63'(dt_reg)) ? TMAX : clock_now + 63'(dt_reg);
      end
      est.pos = xs[0][47:0];
      est.vel = xs[1][47:0];
      est.acc = xs[2][47:0];
      est.tm = clock_now;
      estimates_due.push_back(est);
   endtask

   task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
      if (mismatch_count < 10)
         $display("mismatch %s: expected %h actual %h at %0t", what, exp_v, act_v, $realtime);
      mismatch_count++;
   endtask

   always_comb results_pending = estimates_due.size();

   initial mismatch_count = 0;

   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         for (int i = 0; i < 3; i++) xs[i] = 0;
         load_preset();
         clock_now = 0;
         dt_reg = 25'd559241;
         r_reg = 47'd83886080;
         q_reg = 47'd838861;
         estimates_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_TIME_STEP:  dt_reg = csr_wdata[24:0];
               CSR_MEAS_NOISE: r_reg = csr_wdata;
               CSR_PROC_NOISE: q_reg = csr_wdata;
               default: ;
            endcase
         end
         // response side first: a request accepted this edge cannot answer at once
         if (rsp_tvalid && rsp_tready) begin
            if (estimates_due.size() == 0) begin
               report("unexpected result", 64'd0, rsp_tdata[63:0]);
            end else begin
               want = estimates_due.pop_front();
               if (rsp_tdata[47:0] != want.pos)
                  report("est_position", 64'(want.pos), 64'(rsp_tdata[47:0]));
               if (rsp_tdata[95:48] != want.vel)
                  report("est_velocity", 64'(want.vel), 64'(rsp_tdata[95:48]));
               if (rsp_tdata[143:96] != want.acc)
                  report("est_acceleration", 64'(want.acc), 64'(rsp_tdata[143:96]));
               if (rsp_tdata[190:144] != want.rel)
                  report("relative_error", 64'(want.rel), 64'(rsp_tdata[190:144]));
               if (rsp_tdata[253:191] != want.tm)
                  report("time_now", 64'(want.tm), 64'(rsp_tdata[253:191]));
               if (rsp_tuser[0] != want.inval)
                  report("error_invalid", 64'(want.inval), 64'(rsp_tuser[0]));
            end
         end
         if (req_tvalid && req_tready) filter_step(req_tuser[0], req_tdata);
      end
   end

endmodule

// ----- verif/kalman_filter_three_state_test.sv -----
// kalman_filter_three_state_test: stimulus and verdict for the kalman filter;
// depends on kfts_pkg, the block and kalman_filter_three_state_checker
`timescale 1ns / 100ps

module kalman_filter_three_state_test;
   import kfts_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   // measurement, init_position, init_velocity, init_acceleration, init_time
   logic [255:0] req_tdata = '0;
   // mode
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   // est_position, est_velocity, est_acceleration, relative_error, time_now
   logic [255:0] rsp_tdata;
   // error_invalid
   logic [0:0]   rsp_tuser;
   logic         csr_we = 0;
   csr_type      csr_addr = CSR_TIME_STEP;
   logic [46:0]  csr_wdata = '0;
   int           mismatch_count;
   int           results_pending;
   int           send_idle_pct = 0;
   int           stall_pct = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   kalman_filter_three_state dut (.*);
   kalman_filter_three_state_checker check (.*);

   // random receiver back-pressure
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   // overall time limit, well above the slowest legal run
   initial begin
      #80_000_000;
      $display("kalman_filter_three_state test failed");
      $finish;
   end

   // values of mixed magnitude: full range, small, extremes, zero
   function automatic logic [47:0] pick_value();
      logic [47:0] v;
      case ($urandom_range(9))
         0, 1, 2: v = 48'({$urandom, $urandom});
         3, 4, 5: v = 48'($signed($urandom_range(32'h0FFF_FFFF)) - 32'sh0800_0000);
         6:       v = 48'h7FFF_FFFF_FFFF;
         7:       v = 48'h8000_0000_0000;
         8:       v = 48'($signed($urandom_range(4095)) - 2048) << 20;
         default: v = '0;
      endcase
      return v;
   endfunction

   task automatic send_item(logic mode, logic [47:0] z, logic [47:0] p0, logic [47:0] v0,
                            logic [47:0] a0, logic [62:0] t0);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, t0, a0, v0, p0, z};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic measure(logic [47:0] z);
      send_item(1'b0, z, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                48'({$urandom, $urandom}), 63'({$urandom, $urandom}));
   endtask

   task automatic init_track(logic [47:0] p0, logic [47:0] v0, logic [47:0] a0, logic [62:0] t0);
      send_item(1'b1, 48'({$urandom, $urandom}), p0, v0, a0, t0);
   endtask

   // drain the block completely, then write one register
   task automatic write_reg(csr_type idx, logic [46:0] val);
      req_tvalid <= 0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_we    <= 1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic set_regs(logic [24:0] dt, logic [46:0] r, logic [46:0] q);
      write_reg(CSR_TIME_STEP, 47'(dt));
      write_reg(CSR_MEAS_NOISE, r);
      write_reg(CSR_PROC_NOISE, q);
   endtask

   initial begin
      logic [62:0] t0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset state, zero measurement, extremes, time saturation
      measure(48'd0);
      measure(48'h7FFF_FFFF_FFFF);
      measure(48'h8000_0000_0000);
      measure(48'd16777216);
      init_track(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, '1);
      measure(48'h8000_0000_0000);
      measure(48'd0);
      init_track(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 63'd0);
      measure(48'h7FFF_FFFF_FFFF);
      init_track('0, '0, '0, 63'h7FFF_FFFF_FFFF_FFF0);
      measure(48'd5);
      measure(48'hFFFF_FFFF_FFFF);
      // zero noise lets the innovation variance collapse
      set_regs(25'h1FF_FFFF, 47'd0, 47'd0);
      init_track('0, '0, '0, '0);
      repeat (6) measure(48'd0);
      measure(48'h7FFF_FFFF_FFFF);
      set_regs(25'd0, '1, '1);
      measure(48'd1);
      measure(48'h8000_0000_0000);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         case (ph)
            0: set_regs(25'd559241, 47'd83886080, 47'd838861);
            1: set_regs(25'h1FF_FFFF, 47'd0, 47'd0);
            2: set_regs(25'd0, '1, '1);
            3: set_regs(25'd16777216, 47'd1, '1);
            default: set_regs(25'($urandom), 47'({$urandom, $urandom}),
                              47'($urandom_range(32'h3FFF_FFFF)));
         endcase
         // tracks: an init followed by a run of measurements
         for (int n = 0; n < 212; n++) begin
            if ($urandom_range(11) == 0) begin
               t0 = ($urandom_range(9) == 0) ? 63'h7FFF_FFFF_FFFF_0000
                                             : 63'({$urandom, $urandom});
               init_track(pick_value(), pick_value(), pick_value(), t0);
            end else begin
               measure(pick_value());
            end
         end
      end

      req_tvalid <= 0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("kalman_filter_three_state test passed");
      else
         $display("kalman_filter_three_state test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/kfts_pkg.sv
hdl/kfts_mul.sv
hdl/kfts_div.sv
hdl/kalman_filter_three_state.sv
verif/kalman_filter_three_state_checker.sv
verif/kalman_filter_three_state_test.sv
